FILE: rtl/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the bounded cursor list.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 3;
  localparam int WORD_W   = 32;

  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hBF80_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_REPLACE = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_FIRST   = 3'd3,
    MODE_LAST    = 3'd4,
    MODE_NEXT    = 3'd5,
    MODE_PRIOR   = 3'd6,
    MODE_CLEAR   = 3'd7
  } mode_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } point_t;

  // Broadcast to every cell in the chain during an update.
  typedef struct packed {
    logic             load;      // write the incoming point into one cell
    logic [IDX_W-1:0] load_idx;  // cell that takes the point
    logic             shift;     // pull the neighbor's point down by one
    logic [IDX_W-1:0] shift_lo;  // first cell that shifts
    logic [CNT_W-1:0] held;      // count before the update
  } cell_ctl_t;

endpackage

FILE: rtl/bcl_in_if.sv
// ----------------------------------------------------------------------------
// bcl_in_if
// Request channel: operation code and one point per word.
// ----------------------------------------------------------------------------
interface bcl_in_if
  import bcl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] point_x;
  logic [WORD_W-1:0] point_y;
  logic [WORD_W-1:0] point_z;

  modport source (output valid, mode, point_x, point_y, point_z, input ready);
  modport sink   (input valid, mode, point_x, point_y, point_z, output ready);
endinterface

FILE: rtl/bcl_out_if.sv
// ----------------------------------------------------------------------------
// bcl_out_if
// Response channel: status, cursor point, count and cursor position.
// ----------------------------------------------------------------------------
interface bcl_out_if
  import bcl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [WORD_W-1:0] current_x;
  logic [WORD_W-1:0] current_y;
  logic [WORD_W-1:0] current_z;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  position;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, ok, current_x, current_y, current_z, count, position,
                  is_empty, is_full, input ready);
  modport sink   (input valid, ok, current_x, current_y, current_z, count, position,
                  is_empty, is_full, output ready);
endinterface

FILE: rtl/bcl_cell.sv
// ----------------------------------------------------------------------------
// bcl_cell
// One list slot: holds a point, loads a new one or takes its upper neighbor's.
// ----------------------------------------------------------------------------
module bcl_cell
  import bcl_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] slot,
  input  cell_ctl_t        ctl,
  input  point_t           point_in,
  input  point_t           upper,
  output point_t           stored
);

  logic hit_load;
  logic hit_shift;

  assign hit_load  = ctl.load && (ctl.load_idx == slot);
  // shift only cells at or above the cursor that still have a live neighbor
  assign hit_shift = ctl.shift && (slot >= ctl.shift_lo)
                     && ((CNT_W'(slot) + CNT_W'(1)) < ctl.held);

  always_ff @(posedge clk) begin
    if (hit_load) begin
      stored <= point_in;
    end else if (hit_shift) begin
      stored <= upper;
    end
  end

endmodule

FILE: rtl/bounded_cursor_list.sv
// ----------------------------------------------------------------------------
// bounded_cursor_list
// Bounded ordered list of three-word points with a cursor, built as a chain
// of slot cells.
// ----------------------------------------------------------------------------
// Each request word carries an operation (append, replace, remove, first,
// last, next, prior, clear) and a point; each one yields exactly one response
// word describing the list after the operation. A request is handled in
// steps: as it is taken, the chain of slot cells updates in parallel (an
// append or replace loads one cell, a remove makes each cell from the cursor
// up that has a live upper neighbor take that neighbor's point); then the
// point under the cursor is selected from the chain into the response
// register. A new request is taken once the previous one has moved into the
// response register, so requests do not overlap; a full response register
// holds the selection until the sink drains it. An empty list answers with
// every point word set to -1.0 and position 0. Slot contents are undefined
// after reset; only slots below the count are ever read. Clear resets count
// and cursor and leaves slot contents alone.
// ----------------------------------------------------------------------------
module bounded_cursor_list
  import bcl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bcl_in_if.sink    req,
  bcl_out_if.source rsp
);

  // list control state
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic [IDX_W-1:0] cursor;
  logic [IDX_W-1:0] cursor_next;
  logic             busy;        // cells updated, response not yet registered
  logic             ok_pend;
  logic             ok_next;

  logic             accept;
  logic             rsp_load;
  mode_t            mode;
  point_t           point_in;
  cell_ctl_t        ctl;
  logic             has;
  logic [CNT_W-1:0] held_dec;

  point_t           cell_pt [CAPACITY];

  assign mode     = mode_t'(req.mode);
  assign point_in = '{x: req.point_x, y: req.point_y, z: req.point_z};
  assign req.ready = !busy;
  assign accept   = req.valid && req.ready;
  assign rsp_load = busy && (!rsp.valid || rsp.ready);
  assign has      = (held != '0);
  assign held_dec = held - CNT_W'(1);

  // Decode the operation into a cell broadcast and the next count/cursor.
  always_comb begin
    held_next    = held;
    cursor_next  = cursor;
    ok_next      = 1'b0;
    ctl.load     = 1'b0;
    ctl.load_idx = cursor;
    ctl.shift    = 1'b0;
    ctl.shift_lo = cursor;
    ctl.held     = held;
    unique case (mode)
      MODE_APPEND: begin
        if (held < CNT_W'(CAPACITY)) begin
          ctl.load     = accept;
          ctl.load_idx = held[IDX_W-1:0];
          held_next    = held + CNT_W'(1);
          if (!has) begin
            cursor_next = '0;
          end
          ok_next = 1'b1;
        end
      end
      MODE_REPLACE: begin
        if (has) begin
          ctl.load = accept;
          ok_next  = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (has) begin
          ctl.shift = accept;
          held_next = held_dec;
          // wrap the cursor when it falls off the end
          if (CNT_W'(cursor) >= held_dec) begin
            cursor_next = '0;
          end
          ok_next = 1'b1;
        end
      end
      MODE_FIRST: begin
        if (has) begin
          cursor_next = '0;
          ok_next     = 1'b1;
        end
      end
      MODE_LAST: begin
        if (has) begin
          cursor_next = held_dec[IDX_W-1:0];
          ok_next     = 1'b1;
        end
      end
      MODE_NEXT: begin
        if (has && ((CNT_W'(cursor) + CNT_W'(1)) < held)) begin
          cursor_next = cursor + IDX_W'(1);
          ok_next     = 1'b1;
        end
      end
      MODE_PRIOR: begin
        if (has && (cursor != '0)) begin
          cursor_next = cursor - IDX_W'(1);
          ok_next     = 1'b1;
        end
      end
      MODE_CLEAR: begin
        held_next   = '0;
        cursor_next = '0;
        ok_next     = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Chain of slot cells; the top cell never shifts, so feed it its own point.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    point_t upper;
    if (g == CAPACITY - 1) begin : g_top
      assign upper = cell_pt[g];
    end else begin : g_mid
      assign upper = cell_pt[g + 1];
    end
    bcl_cell u_cell (
      .clk      (clk),
      .slot     (IDX_W'(g)),
      .ctl      (ctl),
      .point_in (point_in),
      .upper    (upper),
      .stored   (cell_pt[g])
    );
  end

  // Control state: count and cursor advance on accept and hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      cursor    <= '0;
      busy      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        held   <= held_next;
        cursor <= cursor_next;
        busy   <= 1'b1;
      end else if (rsp_load) begin
        busy <= 1'b0;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_pend <= ok_next;
    end
  end

  // Response register: select the point under the cursor from the updated chain.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.ok       <= ok_pend;
      rsp.count    <= held;
      rsp.is_empty <= !has;
      rsp.is_full  <= (held == CNT_W'(CAPACITY));
      if (has) begin
        rsp.current_x <= cell_pt[cursor].x;
        rsp.current_y <= cell_pt[cursor].y;
        rsp.current_z <= cell_pt[cursor].z;
        rsp.position  <= cursor;
      end else begin
        rsp.current_x <= EMPTY_WORD;
        rsp.current_y <= EMPTY_WORD;
        rsp.current_z <= EMPTY_WORD;
        rsp.position  <= '0;
      end
    end
  end

endmodule
